// File: hw/rtl/gda_pkg.sv
package gda_pkg;

	// Unit selector codes.
	localparam logic [2:0] FN_DAY        = 3'd0;
	localparam logic [2:0] FN_WEEK       = 3'd1;
	localparam logic [2:0] FN_MONTH      = 3'd2;
	localparam logic [2:0] FN_YEAR       = 3'd3;
	localparam logic [2:0] FN_DECADE     = 3'd4;
	localparam logic [2:0] FN_CENTURY    = 3'd5;
	localparam logic [2:0] FN_MILLENNIUM = 3'd6;

	// Result status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_DATE = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	// Field widths fixed by the interface.
	localparam int YEAR_W  = 14;
	localparam int COUNT_W = 12;
	// Day-step counter holds count times seven.
	localparam int CNT_W   = COUNT_W + 3;
	// Product of the count and the largest year multiplier (1000).
	localparam int PROD_W  = COUNT_W + 10;
	// Starting year plus that product.
	localparam int SUM_W   = PROD_W + 1;
	// Year modulo 400.
	localparam int R400_W  = 9;

	localparam logic [R400_W-1:0] CYCLE_400 = 9'd400;
	localparam logic [R400_W-1:0] LAST_400  = 9'd399;

	// Days per month in a common year, indexed by month.
	localparam logic [4:0] MONTH_LEN [13] = '{5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31,
		5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

	// Result of one calendar step.
	typedef struct packed {
		logic              y_inc;
		logic [R400_W-1:0] r400;
		logic [3:0]        mon;
		logic [4:0]        day;
	} gda_step_t;

	// Leap year from the year taken modulo 400.
	function automatic logic is_leap(input logic [R400_W-1:0] r);
		is_leap = (r[1:0] == 2'd0) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
	endfunction

	// Length of a month; zero for a month code outside 1 to 12.
	function automatic logic [4:0] days_in(input logic [R400_W-1:0] r, input logic [3:0] m);
		if (m == 4'd2) begin
			days_in = is_leap(r) ? 5'd29 : 5'd28;
		end else if (m >= 4'd1 && m <= 4'd12) begin
			days_in = MONTH_LEN[m];
		end else begin
			days_in = 5'd0;
		end
	endfunction

endpackage

// File: hw/rtl/gda_step.sv
module gda_step (
	input  logic [gda_pkg::R400_W-1:0] r400,
	input  logic [3:0]                 mon,
	input  logic [4:0]                 day,
	input  logic                       month_mode,
	output gda_pkg::gda_step_t         nxt
);
	import gda_pkg::*;

	logic              wrap_mon;
	logic [3:0]        mon_inc;
	logic [R400_W-1:0] r400_inc;
	logic [4:0]        len_cur;
	logic [4:0]        len_new;

	// Month and year roll-over shared by both step kinds.
	assign wrap_mon = (mon >= 4'd12);
	assign mon_inc  = wrap_mon ? 4'd1 : mon + 4'd1;
	assign r400_inc = (r400 == LAST_400) ? '0 : r400 + 9'd1;
	assign len_cur  = days_in(r400, mon);
	assign len_new  = days_in(wrap_mon ? r400_inc : r400, mon_inc);

	// One day forward, or one month forward with the day clamped.
	always_comb begin
		nxt.y_inc = 1'b0;
		nxt.r400  = r400;
		nxt.mon   = mon;
		nxt.day   = day;
		if (month_mode) begin
			nxt.y_inc = wrap_mon;
			nxt.r400  = wrap_mon ? r400_inc : r400;
			nxt.mon   = mon_inc;
			nxt.day   = (day > len_new) ? len_new : day;
		end else if (day >= len_cur) begin
			nxt.y_inc = wrap_mon;
			nxt.r400  = wrap_mon ? r400_inc : r400;
			nxt.mon   = mon_inc;
			nxt.day   = 5'd1;
		end else begin
			nxt.day = day + 5'd1;
		end
	end

endmodule

// File: hw/rtl/gregorian_date_adder_top.sv
// Gregorian date adder. A transaction brings a date, a unit selector and a count and
// returns the date advanced by that many days, weeks, months, years, decades, centuries
// or millennia, with a status of ok, invalid input date or year overflow (on an error the
// input date comes back unchanged). One transaction is worked at a time: in_ready is high
// only while the block is idle. The year is first reduced modulo 400 by repeated
// subtraction; days, weeks and months are then stepped one day or one month per cycle
// through a single calendar step unit, and the year-based units use one multiply and one
// add.
module gregorian_date_adder_top #(
	parameter int COUNT_MAX = 4095,
	parameter int YEAR_MAX  = 16383
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [2:0]                  func,
	input  logic [gda_pkg::YEAR_W-1:0]  year_in,
	input  logic [3:0]                  month_in,
	input  logic [4:0]                  day_in,
	input  logic [gda_pkg::COUNT_W-1:0] count,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [gda_pkg::YEAR_W-1:0]  year_out,
	output logic [3:0]                  month_out,
	output logic [4:0]                  day_out,
	output logic [1:0]                  status
);
	import gda_pkg::*;

	localparam int YW = $clog2(YEAR_MAX + 2);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MOD   = 3'd1;
	localparam logic [2:0] S_CHECK = 3'd2;
	localparam logic [2:0] S_STEP  = 3'd3;
	localparam logic [2:0] S_ADD   = 3'd4;
	localparam logic [2:0] S_OUT   = 3'd5;

	logic [2:0]         state_q;
	logic [2:0]         func_q;
	logic [YEAR_W-1:0]  y0_q;
	logic [3:0]         m0_q;
	logic [4:0]         d0_q;
	logic [COUNT_W-1:0] n_q;
	logic [YW-1:0]      year_q;
	logic [3:0]         mon_q;
	logic [4:0]         day_q;
	logic [R400_W-1:0]  r400_q;
	logic [YEAR_W-1:0]  rem_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [PROD_W-1:0]  prod_q;
	logic [1:0]         status_q;

	logic [COUNT_W-1:0] count_sat;
	logic               date_ok;
	logic [9:0]         mult;
	logic [SUM_W-1:0]   sum;
	logic               year_ovf;
	gda_step_t          nxt;

	// Count saturation at the configured maximum.
	assign count_sat = ({4'd0, count} > 16'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX) : count;

	// Validity of the starting date, once its year is reduced modulo 400.
	assign date_ok = (m0_q >= 4'd1) && (m0_q <= 4'd12) && (d0_q != 5'd0) &&
		(d0_q <= days_in(rem_q[R400_W-1:0], m0_q)) &&
		({2'd0, y0_q} <= 16'(YEAR_MAX));

	// Year multiplier of the year-based units.
	always_comb begin
		case (func_q)
			FN_DECADE:     mult = 10'd10;
			FN_CENTURY:    mult = 10'd100;
			FN_MILLENNIUM: mult = 10'd1000;
			default:       mult = 10'd1;
		endcase
	end

	assign sum      = SUM_W'(y0_q) + SUM_W'(prod_q);
	assign year_ovf = (year_q > YW'(YEAR_MAX));

	// Shared calendar step unit.
	gda_step u_step (
		.r400       (r400_q),
		.mon        (mon_q),
		.day        (day_q),
		.month_mode (func_q == FN_MONTH),
		.nxt        (nxt)
	);

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_MOD;
				end
				S_MOD: begin
					if (rem_q < YEAR_W'(CYCLE_400)) state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (!date_ok) begin
						state_q <= S_OUT;
					end else begin
						case (func_q) inside
							FN_DAY, FN_WEEK, FN_MONTH:            state_q <= S_STEP;
							FN_YEAR, FN_DECADE, FN_CENTURY,
							FN_MILLENNIUM:                        state_q <= S_ADD;
							default:                              state_q <= S_OUT;
						endcase
					end
				end
				S_STEP: begin
					if (cnt_q == '0 || year_ovf) state_q <= S_OUT;
				end
				S_ADD: state_q <= S_OUT;
				S_OUT: begin
					if (out_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					func_q   <= func;
					y0_q     <= year_in;
					m0_q     <= month_in;
					d0_q     <= day_in;
					n_q      <= count_sat;
					year_q   <= YW'(year_in);
					mon_q    <= month_in;
					day_q    <= day_in;
					rem_q    <= year_in;
					status_q <= ST_OK;
				end
			end
			S_MOD: begin
				if (rem_q >= YEAR_W'(CYCLE_400)) rem_q <= rem_q - YEAR_W'(CYCLE_400);
			end
			S_CHECK: begin
				r400_q <= rem_q[R400_W-1:0];
				prod_q <= PROD_W'(n_q) * PROD_W'(mult);
				if (func_q == FN_WEEK) begin
					cnt_q <= CNT_W'({3'd0, n_q} * CNT_W'(7));
				end else begin
					cnt_q <= CNT_W'(n_q);
				end
				if (!date_ok) status_q <= ST_BAD_DATE;
			end
			S_STEP: begin
				if (cnt_q == '0 || year_ovf) begin
					// Loop done; on overflow the starting date is returned.
					if (year_ovf) begin
						status_q <= ST_OVERFLOW;
						year_q   <= YW'(y0_q);
						mon_q    <= m0_q;
						day_q    <= d0_q;
					end
				end else begin
					year_q <= year_q + YW'(nxt.y_inc);
					r400_q <= nxt.r400;
					mon_q  <= nxt.mon;
					day_q  <= nxt.day;
					cnt_q  <= cnt_q - CNT_W'(1);
				end
			end
			S_ADD: begin
				if (sum > SUM_W'(YEAR_MAX)) begin
					status_q <= ST_OVERFLOW;
				end else begin
					year_q <= YW'(sum);
				end
			end
			default: ;
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign year_out  = year_q[YEAR_W-1:0];
	assign month_out = mon_q;
	assign day_out   = day_q;
	assign status    = status_q;

	// The block never takes a new transaction while a result is pending.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input taken while result pending");

	// Status is always one of the defined codes.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_BAD_DATE || status == ST_OVERFLOW))
		else $error("undefined status code");

	// A successful result has a month from 1 to 12 and a nonzero day.
	a_ok_date: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_OK) |->
		(month_out >= 4'd1 && month_out <= 4'd12 && day_out >= 5'd1))
		else $error("ok status with an impossible date");

	// The year residue stays below 400 while stepping.
	a_r400_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STEP) |-> (r400_q < CYCLE_400))
		else $error("year residue out of range");

endmodule
